// File: hdl/wsfr_pkg.sv
// Shared types and codes for the WebSocket frame receiver.
// No dependencies; every other file of the block imports this package.
package wsfr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned MAXP_W = 31;
	localparam int unsigned LEN_W  = 64;
	localparam int unsigned KEY_W  = 32;

	localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = MAXP_W'(16384);

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_BYTE      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CTRL_LONG = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DATA_LONG = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
	} wsfr_result_t;

	typedef struct packed {
		logic err;         // error reported, stream frozen
		logic in_payload;  // data frame payload in progress
	} wsfr_status_t;

endpackage

// File: hdl/wsfr_byte_if.sv
// Valid/ready channel carrying one received link byte per request.
// Depends on wsfr_pkg.
interface wsfr_byte_if import wsfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/wsfr_result_if.sv
// Valid/ready channel carrying one receiver result per request.
// Depends on wsfr_pkg.
interface wsfr_result_if import wsfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] payload_byte;
	logic              last;

	modport source (output valid, output kind, output payload_byte, output last, input ready);
	modport sink   (input valid, input kind, input payload_byte, input last, output ready);
endinterface

// File: hdl/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: input stage, parser, result register.
// Depends on wsfr_pkg, wsfr_byte_if, wsfr_result_if and wsfr_parser.
//
// The receiver takes the link byte stream on rx, one byte per request, and
// parses RFC 6455 frame headers: opcode, mask bit, 7-bit length with the
// optional 16-bit or 64-bit big-endian extension, and the optional 4-byte
// mask key. Payload bytes of data frames (opcode 0 to 7) leave on tx unmasked,
// kind 0, with last set on the final byte; a zero-length data frame gives one
// kind 1 marker with last set. Ping, pong and other control payloads are
// swallowed. A close frame (kind 2), a control payload over 125 bytes (kind 3)
// or a data payload over max_payload (kind 4) is reported once, on the byte
// that completes the header, and every later byte is then taken and ignored
// until arst_n. The block sustains one byte per clock while tx keeps up:
// each byte passes through an input register and combinational parser
// logic into the result register, which drives tx, and rx stalls only while
// the result register is full and tx is not ready. max_payload is written
// through cfg_we/cfg_data (reset 16384) and must be changed only while the
// receiver is idle. No clearing pass follows reset.
module websocket_frame_receiver import wsfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	wsfr_byte_if.sink          rx,
	wsfr_result_if.source      tx,
	input  logic               cfg_we,
	input  logic [MAXP_W-1:0]  cfg_data
);

	logic [MAXP_W-1:0] max_payload_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	wsfr_result_t      out_q;
	logic              advance;
	logic              step;
	logic              res_valid;
	wsfr_result_t      res;
	wsfr_status_t      status;

	// Result register is free when empty or being drained this cycle.
	assign advance  = !out_valid_q || tx.ready;
	// Parse the held byte whenever its result (if any) has a place to go.
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	// Hold the limit; write only when idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_data;
		end
	end

	// Input stage: take a new request whenever the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	wsfr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res),
		.status      (status)
	);

	// Result register: load a new result or drop the drained one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.kind         = out_q.kind;
	assign tx.payload_byte = out_q.payload_byte;
	assign tx.last         = out_q.last;

	// Once an error is reported the parser stays frozen.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.err |=> status.err)
		else $error("error state left before reset");

	// No result is produced after an error.
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		status.err |-> !res_valid)
		else $error("result produced after error");

	// Payload bytes come only from the payload phase.
	a_byte_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_BYTE) |-> status.in_payload)
		else $error("payload byte outside data phase");

	// An empty marker always carries last; error reports never do.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.kind != KIND_BYTE) |-> (tx.last == (tx.kind == KIND_EMPTY)))
		else $error("last flag inconsistent with kind");

	// With an empty result register the input is never stalled.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> rx.ready)
		else $error("input stalled with free result register");

endmodule

// File: hdl/wsfr_parser.sv
// Frame header parser, length tracker and unmasking for one byte per cycle while step is high.
// Depends on wsfr_pkg.
module wsfr_parser import wsfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [BYTE_W-1:0]  rx_byte,
	input  logic [MAXP_W-1:0]  max_payload,
	output logic               res_valid,
	output wsfr_result_t       res,
	output wsfr_status_t       status
);

	localparam logic [2:0] PH_HDR0  = 3'd0;
	localparam logic [2:0] PH_HDR1  = 3'd1;
	localparam logic [2:0] PH_EXT16 = 3'd2;
	localparam logic [2:0] PH_EXT64 = 3'd3;
	localparam logic [2:0] PH_MASK  = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;
	localparam logic [2:0] PH_DROP  = 3'd6;
	localparam logic [2:0] PH_ERROR = 3'd7;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [6:0] CTRL_MAX   = 7'd125;
	localparam logic [3:0] OPC_CLOSE  = 4'h8;

	logic [2:0]       phase_q, phase_n;
	logic [3:0]       opc_q, opc_n;
	logic             mask_q, mask_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [2:0]       cnt_q, cnt_n;
	logic [KEY_W-1:0] key_q, key_n;
	logic [1:0]       kidx_q, kidx_n;
	logic             len_done, hdr_done;
	logic [BYTE_W-1:0] key_byte;

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		opc_n     = opc_q;
		mask_n    = mask_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		key_n     = key_q;
		kidx_n    = kidx_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		res_valid = 1'b0;
		res       = '{kind: KIND_BYTE, payload_byte: '0, last: 1'b0};

		case (phase_q)
			PH_HDR0: begin
				opc_n   = rx_byte[3:0];
				phase_n = PH_HDR1;
			end
			PH_HDR1: begin
				mask_n = rx_byte[7];
				cnt_n  = '0;
				len_n  = '0;
				if (rx_byte[6:0] == LEN7_EXT16) begin
					phase_n = PH_EXT16;
				end else if (rx_byte[6:0] == LEN7_EXT64) begin
					phase_n = PH_EXT64;
				end else begin
					len_n    = LEN_W'(rx_byte[6:0]);
					len_done = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_n = {len_q[LEN_W-BYTE_W-1:0], rx_byte};
				cnt_n = cnt_q + 3'd1;
				if (cnt_q == ((phase_q == PH_EXT16) ? 3'd1 : 3'd7)) begin
					len_done = 1'b1;
				end
			end
			PH_MASK: begin
				key_n = {key_q[KEY_W-BYTE_W-1:0], rx_byte};
				cnt_n = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					cnt_n    = '0;
					hdr_done = 1'b1;
				end
			end
			PH_DATA: begin
				kidx_n    = kidx_q + 2'd1;
				len_n     = len_q - LEN_W'(1);
				res_valid = 1'b1;
				res.payload_byte = rx_byte ^ key_byte;
				if (len_q == LEN_W'(1)) begin
					res.last = 1'b1;
					phase_n  = PH_HDR0;
				end
			end
			PH_DROP: begin
				len_n = len_q - LEN_W'(1);
				if (len_q == LEN_W'(1)) begin
					phase_n = PH_HDR0;
				end
			end
			default: begin
			end
		endcase

		// length complete: fetch the key or judge the frame now
		if (len_done) begin
			cnt_n = '0;
			key_n = '0;
			if (mask_n) begin
				phase_n = PH_MASK;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			kidx_n = '0;
			if (opc_q[3]) begin
				if (opc_q == OPC_CLOSE) begin
					phase_n   = PH_ERROR;
					res_valid = 1'b1;
					res.kind  = KIND_CLOSE;
				end else if (len_n[LEN_W-1:7] != '0 || len_n[6:0] > CTRL_MAX) begin
					phase_n   = PH_ERROR;
					res_valid = 1'b1;
					res.kind  = KIND_CTRL_LONG;
				end else begin
					phase_n = (len_n == '0) ? PH_HDR0 : PH_DROP;
				end
			end else if (len_n[LEN_W-1:MAXP_W] != '0 || len_n[MAXP_W-1:0] > max_payload) begin
				phase_n   = PH_ERROR;
				res_valid = 1'b1;
				res.kind  = KIND_DATA_LONG;
			end else if (len_n == '0) begin
				phase_n   = PH_HDR0;
				res_valid = 1'b1;
				res.kind  = KIND_EMPTY;
				res.last  = 1'b1;
			end else begin
				phase_n = PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			opc_q   <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			kidx_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			opc_q   <= opc_n;
			mask_q  <= mask_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			key_q   <= key_n;
			kidx_q  <= kidx_n;
		end
	end

	assign status.err        = (phase_q == PH_ERROR);
	assign status.in_payload = (phase_q == PH_DATA);

endmodule

// File: verif/tb.sv
// Testbench for websocket_frame_receiver: byte-stream stimulus, a frame-parsing predictor
// and an in-order check of every result. Depends on wsfr_pkg, wsfr_byte_if, wsfr_result_if.
`timescale 1ns / 100ps

package ws_rx_check_pkg;
	import wsfr_pkg::*;

	localparam logic [3:0] OP_CONT      = 4'h0;
	localparam logic [3:0] OP_TEXT      = 4'h1;
	localparam logic [3:0] OP_BINARY    = 4'h2;
	localparam logic [3:0] OP_DATA_LAST = 4'h7;
	localparam logic [3:0] OP_CLOSE     = 4'h8;
	localparam logic [3:0] OP_PING      = 4'h9;
	localparam logic [3:0] OP_PONG      = 4'hA;
	localparam logic [3:0] OP_CTRL_LAST = 4'hF;

	localparam logic [6:0] LEN16_MARK   = 7'd126;
	localparam logic [6:0] LEN64_MARK   = 7'd127;
	localparam int unsigned CTRL_MAX_LEN = 125;
	localparam int unsigned EXT16_MAX    = 65535;

	typedef enum logic [2:0] {
		P_HDR0, P_HDR1, P_EXT16, P_EXT64, P_MASK, P_DATA, P_DROP, P_ERROR
	} parse_phase_e;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

	class frame_tracker;
		parse_phase_e      phase;
		logic [3:0]        opcode;
		logic              masked;
		logic [63:0]       flen;
		logic [63:0]       remaining;
		logic [3:0]        hdr_idx;
		logic [31:0]       key;
		logic [1:0]        key_idx;
		logic [MAXP_W-1:0] limit;
		wsfr_result_t      due_results[$];
		int                mismatches;
		int                checked;

		function new();
			phase      = P_HDR0;
			opcode     = '0;
			masked     = 1'b0;
			flen       = '0;
			remaining  = '0;
			hdr_idx    = '0;
			key        = '0;
			key_idx    = '0;
			limit      = MAX_PAYLOAD_RST;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void set_limit(logic [MAXP_W-1:0] value);
			limit = value;
		endfunction

		function void push(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pbyte, logic last);
			wsfr_result_t r;
			r.kind         = kind;
			r.payload_byte = pbyte;
			r.last         = last;
			due_results.push_back(r);
		endfunction

		// Judge the frame once length and key are in: close, then control length, then data length.
		function void header_complete();
			key_idx   = '0;
			remaining = flen;
			if (opcode >= OP_CLOSE) begin
				if (opcode == OP_CLOSE) begin
					phase = P_ERROR;
					push(KIND_CLOSE, '0, 1'b0);
				end else if (flen > 64'(CTRL_MAX_LEN)) begin
					phase = P_ERROR;
					push(KIND_CTRL_LONG, '0, 1'b0);
				end else begin
					phase = (flen == 0) ? P_HDR0 : P_DROP;
				end
			end else if (flen > 64'(limit)) begin
				phase = P_ERROR;
				push(KIND_DATA_LONG, '0, 1'b0);
			end else if (flen == 0) begin
				phase = P_HDR0;
				push(KIND_EMPTY, '0, 1'b1);
			end else begin
				phase = P_DATA;
			end
		endfunction

		function void length_complete();
			hdr_idx = '0;
			key     = '0;
			if (masked)
				phase = P_MASK;
			else
				header_complete();
		endfunction

		// Advance the parser by one accepted byte and queue what it yields.
		function void take_byte(logic [BYTE_W-1:0] b);
			logic [7:0] kb;
			case (phase)
				P_HDR0: begin
					opcode = b[3:0];
					phase  = P_HDR1;
				end
				P_HDR1: begin
					masked  = b[7];
					hdr_idx = '0;
					flen    = '0;
					if (b[6:0] == LEN16_MARK) begin
						phase = P_EXT16;
					end else if (b[6:0] == LEN64_MARK) begin
						phase = P_EXT64;
					end else begin
						flen = 64'(b[6:0]);
						length_complete();
					end
				end
				P_EXT16, P_EXT64: begin
					flen    = {flen[55:0], b};
					hdr_idx = hdr_idx + 4'd1;
					if (hdr_idx == ((phase == P_EXT16) ? 4'd2 : 4'd8))
						length_complete();
				end
				P_MASK: begin
					key     = {key[23:0], b};
					hdr_idx = hdr_idx + 4'd1;
					if (hdr_idx == 4'd4) begin
						hdr_idx = '0;
						header_complete();
					end
				end
				P_DATA: begin
					kb        = 8'(key >> (24 - 8 * key_idx));
					key_idx   = key_idx + 2'd1;
					remaining = remaining - 64'd1;
					if (remaining == 0) begin
						phase = P_HDR0;
						push(KIND_BYTE, b ^ kb, 1'b1);
					end else begin
						push(KIND_BYTE, b ^ kb, 1'b0);
					end
				end
				P_DROP: begin
					remaining = remaining - 64'd1;
					if (remaining == 0)
						phase = P_HDR0;
				end
				default: ;
			endcase
		endfunction

		task report(string what, int got, int want);
			mismatches++;
			if (mismatches <= 100)
				$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		endtask

		task check_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pbyte, logic last);
			wsfr_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				report("unexpected result kind", int'(kind), -1);
				return;
			end
			want = due_results.pop_front();
			if (kind != want.kind)
				report("kind", int'(kind), int'(want.kind));
			if (pbyte != want.payload_byte)
				report("payload_byte", int'(pbyte), int'(want.payload_byte));
			if (last != want.last)
				report("last", int'(last), int'(want.last));
		endtask
	endclass

endpackage

module tb;
	import wsfr_pkg::*;
	import ws_rx_check_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [MAXP_W-1:0] cfg_data;

	// Idle rates in percent per cycle: sender gaps and receiver stalls.
	int src_idle_pct = 6;
	int snk_stall_pct = 84;

	int    bytes_sent = 0;
	int    frames_sent = 0;
	string err_name = "none";

	frame_tracker board = new();

	wsfr_byte_if   rx_if();
	wsfr_result_if tx_if();

	websocket_frame_receiver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_if),
		.tx       (tx_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side: stall at random, drawn fresh every cycle.
	initial begin
		tx_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			tx_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Sample the result handshake at the falling edge, where every signal has settled;
	// a request seen here is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && tx_if.valid && tx_if.ready)
			board.check_result(tx_if.kind, tx_if.payload_byte, tx_if.last);
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("websocket_frame_receiver verification failed");
		$finish;
	end

	// Offer one byte, hold it until taken, then let the predictor see it.
	// Call at a rising edge; returns at the rising edge that took the byte.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(negedge clk);
		while (!rx_if.ready)
			@(negedge clk);
		@(posedge clk);
		board.take_byte(b);
		bytes_sent++;
	endtask

	// Drop valid and hold off until every expected result is out, plus a tail for
	// bytes that are still in flight but yield nothing.
	task automatic settle(input int tail);
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_limit(input logic [MAXP_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		board.set_limit(value);
	endtask

	function automatic len_form_e pick_form(input logic [63:0] len);
		int r;
		r = $urandom_range(99);
		if (len > 64'(EXT16_MAX))
			return LEN_EXT64;
		if (len > 64'(CTRL_MAX_LEN))
			return (r < 50) ? LEN_EXT16 : LEN_EXT64;
		return (r < 60) ? LEN_SHORT : ((r < 80) ? LEN_EXT16 : LEN_EXT64);
	endfunction

	// Emit header, optional extended length and key, then the payload if asked.
	// FIN and RSV bits are random, the block must ignore them.
	task automatic send_frame(input logic [3:0] op, input logic [63:0] len, input logic masked,
			input len_form_e form, input bit with_payload);
		logic [6:0]  len7;
		int          i;
		longint unsigned j;
		case (form)
			LEN_SHORT: len7 = len[6:0];
			LEN_EXT16: len7 = LEN16_MARK;
			default:   len7 = LEN64_MARK;
		endcase
		send_byte({4'($urandom_range(15)), op});
		send_byte({masked, len7});
		if (form == LEN_EXT16) begin
			for (i = 1; i >= 0; i--)
				send_byte(len[i*8 +: 8]);
		end else if (form == LEN_EXT64) begin
			for (i = 7; i >= 0; i--)
				send_byte(len[i*8 +: 8]);
		end
		if (masked)
			repeat (4) send_byte(8'($urandom_range(255)));
		if (with_payload) begin
			for (j = 0; j < len; j++)
				send_byte(8'($urandom_range(255)));
		end
		frames_sent++;
	endtask

	// Well-formed frame with random content: data frames within the current limit,
	// or ping/pong/reserved control frames up to the control length limit.
	task automatic send_random_frame();
		logic [3:0]      op;
		longint unsigned len;
		longint unsigned cap;
		logic            masked;
		int              r;
		masked = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 25) begin
			op = 4'($urandom_range(OP_PING, OP_CTRL_LAST));
			r  = $urandom_range(99);
			if (r < 20)
				len = 0;
			else if (r < 30)
				len = CTRL_MAX_LEN;
			else if (r < 40)
				len = $urandom_range(1, CTRL_MAX_LEN);
			else
				len = $urandom_range(1, 20);
		end else begin
			op  = 4'($urandom_range(OP_CONT, OP_DATA_LAST));
			cap = (board.limit < 40) ? longint'(board.limit) : 40;
			if ($urandom_range(9) == 0)
				cap = (board.limit < 300) ? longint'(board.limit) : 300;
			r = $urandom_range(99);
			if (r < 10)
				len = 0;
			else if (r < 15)
				len = cap;
			else
				len = $urandom_range(1, int'(cap));
		end
		send_frame(op, 64'(len), masked, pick_form(64'(len)), 1'b1);
	endtask

	task automatic run_random(input int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget)
			send_random_frame();
	endtask

	// An error freezes the block until reset, so only one can be reported per run:
	// pick it at random, then follow with noise that must be taken and ignored.
	task automatic send_error_frame();
		logic [63:0] len;
		logic [3:0]  op;
		int          r;
		r = $urandom_range(2);
		case (r)
			0: begin
				err_name = "close";
				op  = OP_CLOSE;
				len = 64'($urandom_range(0, CTRL_MAX_LEN));
			end
			1: begin
				err_name = "control too long";
				op = 4'($urandom_range(OP_PING, OP_CTRL_LAST));
				case ($urandom_range(2))
					0:       len = 64'(CTRL_MAX_LEN + 1);
					1:       len = 64'($urandom_range(CTRL_MAX_LEN + 1, EXT16_MAX));
					default: len = {1'b1, 31'($urandom), 32'($urandom)};
				endcase
			end
			default: begin
				err_name = "data too long";
				op = 4'($urandom_range(OP_CONT, OP_DATA_LAST));
				case ($urandom_range(2))
					0:       len = 64'(board.limit) + 64'd1;
					1:       len = 64'(board.limit) + 64'($urandom_range(1, 1000));
					default: len = {1'b1, 31'($urandom), 32'($urandom)};
				endcase
			end
		endcase
		send_frame(op, len, 1'($urandom_range(1)), pick_form(len), 1'b0);
		repeat (40) send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset limit: empty data frame, empty ping, masked data,
		// dropped pong payload, data length sent as a 16-bit extension.
		send_frame(OP_TEXT, 64'd0, 1'b0, LEN_SHORT, 1'b1);
		send_frame(OP_PING, 64'd0, 1'b0, LEN_SHORT, 1'b1);
		send_frame(OP_BINARY, 64'd3, 1'b1, LEN_SHORT, 1'b1);
		send_frame(OP_PONG, 64'd2, 1'b0, LEN_SHORT, 1'b1);
		send_frame(OP_CONT, 64'd1, 1'b0, LEN_EXT16, 1'b1);

		// Limit of 1: only data frames of zero or one byte pass.
		settle(4);
		write_limit(MAXP_W'(1));
		run_random(500);

		// Largest limit with the idle rates swapped; pause once mid-stream until drained.
		settle(4);
		src_idle_pct  = 84;
		snk_stall_pct = 6;
		write_limit({MAXP_W{1'b1}});
		run_random(300);
		settle(0);
		run_random(300);

		// Random modest limit, no idling on either side, then the closing error.
		settle(4);
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		write_limit(MAXP_W'($urandom_range(2, 300)));
		run_random(600);
		send_error_frame();
		settle(12);

		$display("Covered %0d bytes in %0d frames, %0d results checked over four limit settings,",
			bytes_sent, frames_sent, board.checked);
		$display("ending on a %s error followed by ignored bytes.", err_name);
		if (board.mismatches == 0 && board.due_results.size() == 0) begin
			$display("websocket_frame_receiver verification clean");
		end else begin
			$display("websocket_frame_receiver verification failed");
		end
		$finish;
	end

endmodule
